>>> sv/tcl_pkg.sv
// package: types, constants and state codes for the threshold cluster labeler
package tcl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int DIMENSIONS_DEF = 3;
    localparam int FIELD_BITS     = 24;
    localparam int THR_BITS       = 52;
    localparam int IDX_BITS       = 6;
    localparam int CNT_BITS       = 7;
    localparam int SQ_BITS        = 2 * FIELD_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] pos_x;
        logic signed [FIELD_BITS-1:0] pos_y;
        logic signed [FIELD_BITS-1:0] pos_z;
        logic                         last_point;
    } in_item_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] cluster_number;
        logic [IDX_BITS-1:0] point_index;
        logic [CNT_BITS-1:0] cluster_size;
        logic                last_in_cluster;
        logic                last_overall;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED,
        ST_QRD,
        ST_POP,
        ST_RD,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_TEST,
        ST_EMIT_SCAN,
        ST_EMIT_WAIT,
        ST_DONE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic seed_clear;
        logic seed_take;
        logic pop;
        logic issue_read;
        logic link_test;
        logic scan_step;
        logic emit;
        logic finish;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic seed_end;
        logic seed_hit;
        logic queue_empty;
        logic q_end;
        logic scan_end;
        logic scan_hit;
        logic out_busy;
    } sts_t;

endpackage

>>> sv/tcl_ctrl.sv
// controller state machine sequencing load, search, emit and clear
module tcl_ctrl
    import tcl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_fire,
    input  logic   in_last,
    input  sts_t   sts,
    output logic   in_ready,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire && in_last) state_next = ST_SEED;
            end
            ST_SEED: begin
                if (sts.seed_end) state_next = ST_DONE;
                else if (sts.seed_hit) state_next = ST_QRD;
            end
            ST_QRD:  state_next = ST_POP;
            ST_POP: begin
                if (sts.queue_empty) state_next = ST_EMIT_SCAN;
                else state_next = ST_RD;
            end
            ST_RD:   state_next = ST_D1;
            ST_D1:   state_next = ST_D2;
            ST_D2:   state_next = ST_D3;
            ST_D3:   state_next = ST_TEST;
            ST_TEST: begin
                if (sts.q_end) state_next = ST_QRD;
                else state_next = ST_RD;
            end
            ST_EMIT_SCAN: begin
                if (sts.scan_end) state_next = ST_SEED;
                else if (sts.scan_hit) state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (!sts.out_busy) state_next = ST_EMIT_SCAN;
            end
            ST_DONE: begin
                if (!sts.out_busy) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_SEED: begin
                cmd.seed_take = sts.seed_hit && !sts.seed_end;
                cmd.seed_clear = 1'b1;
            end
            ST_POP:  cmd.pop = !sts.queue_empty;
            ST_RD:   cmd.issue_read = 1'b1;
            ST_TEST: cmd.link_test = 1'b1;
            ST_EMIT_SCAN: begin
                cmd.scan_step = !sts.scan_hit || sts.scan_end;
            end
            ST_EMIT_WAIT: begin
                cmd.emit = !sts.out_busy;
            end
            ST_DONE: cmd.finish = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

>>> sv/tcl_dpath.sv
// datapath: point stores, distance pipeline, queue, marks and output register
module tcl_dpath
    import tcl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIMENSIONS = DIMENSIONS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  in_item_t            in_item,
    input  logic [THR_BITS-1:0] thr,
    input  logic                m_ready,
    output sts_t                sts,
    output out_item_t           out_item,
    output logic                out_valid
);

    localparam int PB = $clog2(MAX_POINTS);
    localparam logic [CNT_BITS-1:0] MAXP = CNT_BITS'(MAX_POINTS);

    logic signed [COORD_BITS-1:0] xs [MAX_POINTS];
    logic signed [COORD_BITS-1:0] ys [MAX_POINTS];
    logic signed [COORD_BITS-1:0] zs [MAX_POINTS];
    logic [PB-1:0]                fq [MAX_POINTS];

    logic [MAX_POINTS-1:0] vis_reg, mem_reg;
    logic [CNT_BITS-1:0] cnt_reg, seed_reg, head_reg, tail_reg, size_reg;
    logic [CNT_BITS-1:0] q_reg, scan_reg, left_reg, clus_reg;
    logic [PB-1:0]       p_reg, q_d1_reg, q_d2_reg, q_d3_reg, q_d4_reg;
    logic [PB-1:0]       qpop_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg;
    logic [COORD_BITS:0]  dx_reg, dy_reg, dz_reg;
    logic [SUM_BITS-1:0]  sx_reg, sy_reg, sz_reg;
    logic [SUM_BITS-1:0]  dist_reg;

    logic                  ov_reg;
    out_item_t             o_reg;

    function automatic logic [COORD_BITS:0] absd(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        return d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
    endfunction

    // coordinate narrowing: keep low COORD_BITS bits
    logic signed [COORD_BITS-1:0] ix, iy, iz;
    assign ix = in_item.pos_x[COORD_BITS-1:0];
    assign iy = in_item.pos_y[COORD_BITS-1:0];
    assign iz = in_item.pos_z[COORD_BITS-1:0];

    logic [PB-1:0] sidx, qidx, scidx, tidx;
    assign sidx  = seed_reg[PB-1:0];
    assign qidx  = q_reg[PB-1:0];
    assign scidx = scan_reg[PB-1:0];
    assign tidx  = tail_reg[PB-1:0];

    // distance pipeline: issue in RD, dist_reg valid in TEST after D1..D3
    logic link;
    assign link = !vis_reg[q_d4_reg] && (THR_BITS'(dist_reg) < thr);

    // points below the fill count; the set is exhausted once all are visited
    logic [MAX_POINTS-1:0] used_mask;
    logic                  all_vis;
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) used_mask[i] = (CNT_BITS'(i) < cnt_reg);
    end
    assign all_vis = ((vis_reg & used_mask) == used_mask);

    always_ff @(posedge aclk) begin
        if (cmd.load && cnt_reg < MAXP) begin
            xs[cnt_reg[PB-1:0]] <= ix;
            ys[cnt_reg[PB-1:0]] <= iy;
            zs[cnt_reg[PB-1:0]] <= iz;
        end
        // queue memory: seed and link pushes share one write port
        if (cmd.seed_take) fq[0] <= sidx;
        else if (cmd.link_test && link && tail_reg < MAXP) fq[tidx] <= q_d4_reg;
        qpop_reg <= fq[head_reg[PB-1:0]];
        // distance pipeline, read then subtract then square then sum
        px_reg <= xs[p_reg];
        py_reg <= ys[p_reg];
        pz_reg <= zs[p_reg];
        qx_reg <= xs[qidx];
        qy_reg <= ys[qidx];
        qz_reg <= zs[qidx];
        dx_reg <= absd(px_reg, qx_reg);
        dy_reg <= absd(py_reg, qy_reg);
        dz_reg <= absd(pz_reg, qz_reg);
        sx_reg <= SUM_BITS'(dx_reg * dx_reg);
        sy_reg <= (DIMENSIONS > 1) ? SUM_BITS'(dy_reg * dy_reg) : '0;
        sz_reg <= (DIMENSIONS > 2) ? SUM_BITS'(dz_reg * dz_reg) : '0;
        dist_reg <= sx_reg + sy_reg + sz_reg;
        q_d1_reg <= qidx;
        q_d2_reg <= q_d1_reg;
        q_d3_reg <= q_d2_reg;
        q_d4_reg <= q_d3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg <= '0; mem_reg <= '0; cnt_reg <= '0; seed_reg <= '0;
            head_reg <= '0; tail_reg <= '0; size_reg <= '0; q_reg <= '0;
            scan_reg <= '0; left_reg <= '0; clus_reg <= '0; p_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (cmd.emit) ov_reg <= 1'b1;
            else if (ov_reg && m_ready) ov_reg <= 1'b0;
            if (cmd.load && cnt_reg < MAXP) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.seed_clear) begin
                if (cmd.seed_take) begin
                    vis_reg[sidx]  <= 1'b1;
                    mem_reg        <= MAX_POINTS'(1) << sidx;
                    head_reg <= '0;
                    tail_reg <= CNT_BITS'(1);
                    size_reg <= CNT_BITS'(1);
                    clus_reg <= clus_reg + 1'b1;
                    scan_reg <= '0;
                end
                if (!sts.seed_end) seed_reg <= seed_reg + 1'b1;
            end
            if (cmd.pop) begin
                p_reg    <= qpop_reg;
                head_reg <= head_reg + 1'b1;
                q_reg    <= '0;
            end
            if (cmd.issue_read) q_reg <= q_reg + 1'b1;
            if (cmd.link_test && link) begin
                vis_reg[q_d4_reg] <= 1'b1;
                mem_reg[q_d4_reg] <= 1'b1;
                size_reg <= size_reg + 1'b1;
                if (tail_reg < MAXP) tail_reg <= tail_reg + 1'b1;
            end
            if (cmd.pop || cmd.seed_take) left_reg <= cmd.seed_take ? CNT_BITS'(1) : size_reg;
            if (cmd.emit) begin
                o_reg.cluster_number  <= clus_reg;
                o_reg.point_index     <= IDX_BITS'(scidx);
                o_reg.cluster_size    <= size_reg;
                o_reg.last_in_cluster <= (left_reg == CNT_BITS'(1));
                o_reg.last_overall    <= (left_reg == CNT_BITS'(1)) && all_vis;
                left_reg  <= left_reg - 1'b1;
                scan_reg  <= scan_reg + 1'b1;
            end else if (cmd.scan_step && !sts.scan_end) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.finish) begin
                vis_reg <= '0; mem_reg <= '0; cnt_reg <= '0; seed_reg <= '0;
                clus_reg <= '0;
            end
        end
    end

    // queue read is registered; the controller passes through QRD before each pop
    assign sts.seed_end    = (seed_reg >= cnt_reg);
    assign sts.seed_hit    = !sts.seed_end && !vis_reg[sidx];
    assign sts.queue_empty = (head_reg >= tail_reg) || (head_reg >= MAXP);
    assign sts.q_end       = (q_d4_reg == PB'(cnt_reg - 1'b1));
    assign sts.scan_end    = (scan_reg >= cnt_reg);
    assign sts.scan_hit    = !sts.scan_end && mem_reg[scidx];
    assign sts.out_busy    = ov_reg && !m_ready;

    assign out_valid = ov_reg;
    assign out_item  = o_reg;

endmodule

>>> sv/threshold_cluster_labeler_core.sv
// top level: threshold cluster labeler core, controller plus datapath
//
// s_ channel takes one point per transaction into a 64-entry store.
// the point with last_point set starts friends-of-friends clustering: two
// points link when their squared distance is strictly below threshold_sq.
// m_ channel returns one transaction per member, cluster by cluster in
// ascending point order, with cluster size and last flags.
// s_ready is low from the final point until every result has been taken.
// loading: one point per cycle. clustering: each popped point passes the
// QRD and POP states, then is compared against all n stored points, one
// pair at a time, through a four-stage read/subtract/square/sum pipeline
// (RD, D1, D2, D3, TEST); each cluster then scans all n points, with an
// extra EMIT_WAIT state for each member emitted.
// results sit in one output register; a stalled receiver holds the search
// at the next emission, nothing is dropped. the user writes threshold_sq
// through cfg_wr_en and cfg_wr_data only while idle; the core does not
// check this. reset (aresetn low, synchronous) clears the marks, counters
// and threshold; coordinate stores need no reset.
module threshold_cluster_labeler_core
    import tcl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIMENSIONS = DIMENSIONS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [THR_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    logic [THR_BITS-1:0] thr_reg;
    cmd_t cmd;
    sts_t sts;
    logic in_fire;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= '0;
        else if (cfg_wr_en) thr_reg <= cfg_wr_data;
    end

    assign in_fire = s_valid && s_ready;

    tcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_data.last_point),
        .sts      (sts),
        .in_ready (s_ready),
        .cmd      (cmd)
    );

    tcl_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .DIMENSIONS (DIMENSIONS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_item   (s_data),
        .thr       (thr_reg),
        .m_ready   (m_ready),
        .sts       (sts),
        .out_item  (m_data),
        .out_valid (m_valid)
    );

endmodule
